@@ rtl/core/rfte_pkg.sv @@
// ----------------------------------------------------------------------------
// rfte_pkg
// Shared types and constants of the RGB frame transform engine.
// ----------------------------------------------------------------------------
package rfte_pkg;

	localparam int SIDE      = 256;
	localparam int NPIX      = SIDE * SIDE;
	localparam int AW        = $clog2(NPIX);
	localparam int PW        = 24;
	localparam logic [7:0] THR_RESET = 8'd30;
	localparam logic [7:0] LIM2 = 8'(SIDE / 2);
	localparam logic [7:0] LIM3 = 8'(SIDE / 3);
	localparam logic [7:0] LIM4 = 8'(SIDE / 4);
	localparam logic [7:0] LAST = 8'(SIDE - 1);

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_APPLY = 2'd2;
	localparam logic [1:0] MODE_UNDEF = 2'd3;

	localparam logic [3:0] OP_FLIPH   = 4'd0;
	localparam logic [3:0] OP_FLIPV   = 4'd1;
	localparam logic [3:0] OP_ROT90   = 4'd2;
	localparam logic [3:0] OP_ROT180  = 4'd3;
	localparam logic [3:0] OP_ROT270  = 4'd4;
	localparam logic [3:0] OP_ENLARGE = 4'd5;
	localparam logic [3:0] OP_SHRINK  = 4'd6;
	localparam logic [3:0] OP_DARKEN  = 4'd7;
	localparam logic [3:0] OP_LIGHTEN = 4'd8;
	localparam logic [3:0] OP_EDGES   = 4'd9;

	localparam logic [1:0] ARG_BAD_SHRINK = 2'd3;
	localparam logic [2:0] REG_THRESHOLD  = 3'd0;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] row;
		logic [7:0] column;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [3:0] operation;
		logic [1:0] argument;
	} item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       status;
	} result_t;

	typedef struct packed {
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [PW-1:0] wr_data;
		logic          done;
	} seq_ctl_t;

endpackage

@@ rtl/core/rfte_ram.sv @@
// ----------------------------------------------------------------------------
// rfte_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module rfte_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/rfte_seq.sv @@
// ----------------------------------------------------------------------------
// rfte_seq
// Whole-frame pass sequencer: walks every destination pixel, reads its
// source pixels and writes the transformed pixel into the other bank.
// ----------------------------------------------------------------------------
module rfte_seq import rfte_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [3:0]    op,
	input  logic [1:0]    arg,
	input  logic [7:0]    thr,
	input  logic [PW-1:0] rdata,
	output seq_ctl_t      ctl
);

	logic          run_q;
	logic [7:0]    r_q, c_q;
	logic [1:0]    sub_q;
	logic [3:0]    op_q;
	logic [1:0]    arg_q;
	logic [PW-1:0] cap0_q, cap1_q;
	logic [1:0]    nreads;
	logic          wstep;
	logic [7:0]    sr, sc, lim;
	logic [2:0]    k;
	logic [11:0]   kr, kc;
	logic [PW-1:0] val;

	function automatic logic [7:0] edge_ch(input logic [7:0] v, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] t);
		logic [7:0] da, db;
		da = (v > a) ? v - a : a - v;
		db = (v > b) ? v - b : b - v;
		return (da >= t || db >= t) ? 8'd0 : 8'd255;
	endfunction

	function automatic logic [7:0] light(input logic [7:0] v);
		return v[7] ? 8'd255 : {v[6:0], 1'b0};
	endfunction

	assign nreads = (op_q == OP_EDGES) ? 2'd3 : 2'd1;
	assign wstep  = run_q && (sub_q == nreads);
	assign k      = 3'(arg_q) + 3'd2;
	assign kr     = 12'(k) * 12'({1'b0, r_q} + 9'd1) - 12'd1;
	assign kc     = 12'(k) * 12'({1'b0, c_q} + 9'd1) - 12'd1;

	always_comb begin
		unique case (arg_q)
			2'd0:    lim = LIM2;
			2'd1:    lim = LIM3;
			default: lim = LIM4;
		endcase
	end

	always_comb begin
		sr = r_q;
		sc = c_q;
		unique case (op_q)
			OP_FLIPH:   sc = ~c_q;
			OP_FLIPV:   sr = ~r_q;
			OP_ROT90: begin
				sr = c_q;
				sc = ~r_q;
			end
			OP_ROT180: begin
				sr = ~r_q;
				sc = ~c_q;
			end
			OP_ROT270: begin
				sr = ~c_q;
				sc = r_q;
			end
			OP_ENLARGE: begin
				sr = {arg_q[1], r_q[7:1]};
				sc = {arg_q[0], c_q[7:1]};
			end
			OP_SHRINK: begin
				sr = kr[7:0];
				sc = kc[7:0];
			end
			OP_EDGES: begin
				if (sub_q == 2'd1) begin
					sc = c_q + 8'd1;
				end else if (sub_q == 2'd2) begin
					sr = r_q + 8'd1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (op_q)
			OP_SHRINK:  val = (r_q < lim && c_q < lim) ? rdata : {PW{1'b1}};
			OP_DARKEN:  val = {1'b0, rdata[23:17], 1'b0, rdata[15:9], 1'b0, rdata[7:1]};
			OP_LIGHTEN: val = {light(rdata[23:16]), light(rdata[15:8]), light(rdata[7:0])};
			OP_EDGES: begin
				if (r_q == LAST || c_q == LAST) begin
					val = cap0_q;
				end else begin
					val = {edge_ch(cap0_q[23:16], cap1_q[23:16], rdata[23:16], thr),
						edge_ch(cap0_q[15:8], cap1_q[15:8], rdata[15:8], thr),
						edge_ch(cap0_q[7:0], cap1_q[7:0], rdata[7:0], thr)};
				end
			end
			default:    val = rdata;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			r_q   <= '0;
			c_q   <= '0;
			sub_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			r_q   <= '0;
			c_q   <= '0;
			sub_q <= '0;
		end else if (run_q) begin
			if (wstep) begin
				sub_q <= '0;
				c_q   <= c_q + 8'd1;
				if (c_q == LAST) begin
					r_q <= r_q + 8'd1;
					if (r_q == LAST) begin
						run_q <= 1'b0;
					end
				end
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q  <= op;
			arg_q <= arg;
		end
		if (run_q && sub_q == 2'd1) begin
			cap0_q <= rdata;
		end
		if (run_q && sub_q == 2'd2) begin
			cap1_q <= rdata;
		end
	end

	assign ctl.rd_addr = {sr, sc};
	assign ctl.wr_en   = wstep;
	assign ctl.wr_addr = {r_q, c_q};
	assign ctl.wr_data = val;
	assign ctl.done    = wstep && r_q == LAST && c_q == LAST;

endmodule

@@ rtl/core/rgb_frame_transform_engine.sv @@
// ----------------------------------------------------------------------------
// rgb_frame_transform_engine
// Square RGB frame store with whole-frame flip, rotate, scale and filter.
// ----------------------------------------------------------------------------
// Pixel writes can be taken back to back while the result side does not stall;
// a pixel read holds off the next item while the registered read of the frame
// RAM delivers its data. A frame operation makes one pass over all 65536
// pixels from the active bank into the other and then swaps banks. Most
// operations read one source pixel per destination pixel; edge marking reads
// three through the single read port. The input stalls during a pass.
module rgb_frame_transform_engine import rfte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t        st_q, st_d;
	logic          bank_q, rdp_q;
	logic [7:0]    thr_q;
	logic          acc, out_free, start, bad;
	seq_ctl_t      ctl;
	logic [AW-1:0] raddr, waddr;
	logic [PW-1:0] wdata, rd0, rd1, rdata;
	logic          wen, wbank;

	assign pready   = 1'b1;
	assign prdata   = (paddr == REG_THRESHOLD) ? {24'd0, thr_q} : 32'd0;
	assign out_free = !result_valid || !result_stall;
	assign item_stall = (st_q != ST_IDLE) || rdp_q || !out_free;
	assign acc   = item_valid && !item_stall;
	assign bad   = item.operation > OP_EDGES ||
		(item.operation == OP_SHRINK && item.argument == ARG_BAD_SHRINK);
	assign start = acc && item.mode == MODE_APPLY && !bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && paddr == REG_THRESHOLD) begin
			thr_q <= pwdata[7:0];
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (start) st_d = ST_RUN;
			ST_RUN:  if (ctl.done) st_d = ST_FIN;
			ST_FIN:  if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			bank_q       <= 1'b0;
			rdp_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			st_q  <= st_d;
			rdp_q <= acc && item.mode == MODE_READ;
			if (st_q == ST_FIN && out_free) begin
				bank_q <= !bank_q;
			end
			if ((acc && item.mode != MODE_READ && !start) || rdp_q ||
					(st_q == ST_FIN && out_free)) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdp_q) begin
			result <= {rdata, 1'b0};
		end else if (st_q == ST_FIN && out_free) begin
			result <= '0;
		end else if (acc && !start) begin
			result <= {24'd0, item.mode == MODE_APPLY || item.mode == MODE_UNDEF};
		end
	end

	rfte_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (item.operation),
		.arg    (item.argument),
		.thr    (thr_q),
		.rdata  (rdata),
		.ctl    (ctl)
	);

	assign raddr = (st_q == ST_RUN) ? ctl.rd_addr : {item.row, item.column};
	assign wen   = (st_q == ST_RUN) ? ctl.wr_en : (acc && item.mode == MODE_WRITE);
	assign waddr = (st_q == ST_RUN) ? ctl.wr_addr : {item.row, item.column};
	assign wdata = (st_q == ST_RUN) ? ctl.wr_data :
		{item.red_in, item.green_in, item.blue_in};
	assign wbank = (st_q == ST_RUN) ? !bank_q : bank_q;
	assign rdata = bank_q ? rd1 : rd0;

	rfte_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_bank0 (
		.clk   (clk),
		.we    (wen && !wbank),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd0)
	);

	rfte_ram #(.WIDTH(PW), .DEPTH(NPIX)) u_bank1 (
		.clk   (clk),
		.we    (wen && wbank),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd1)
	);

endmodule

@@ rtl/core/rfte_checker.sv @@
// ----------------------------------------------------------------------------
// rfte_checker
// Port-level checks of the RGB frame transform engine.
// ----------------------------------------------------------------------------
module rfte_checker import rfte_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result beat changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |->
		result.red_out == 8'd0 && result.green_out == 8'd0 && result.blue_out == 8'd0)
		else $error("failed beat carries pixel data");

	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.mode == MODE_WRITE |=>
		result_valid && !result.status)
		else $error("pixel write not acknowledged in the next cycle");

endmodule

bind rgb_frame_transform_engine rfte_checker u_rfte_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
